>>> rtl/nfass_pkg.sv
// ----------------------------------------------------------------------------
// nfass_pkg
// Shared types and constants for the NFA state-set stepper.
// ----------------------------------------------------------------------------
package nfass_pkg;

  // default sizing
  localparam int NumStatesDef  = 32;
  localparam int NumSymbolsDef = 256;

  // field widths fixed by the interface
  localparam int ActW   = 2;
  localparam int StateW = 5;
  localparam int SymW   = 8;
  localparam int SetW   = 32;
  localparam int CfgW   = 32;

  // item actions
  typedef enum logic [ActW-1:0] {
    ACT_ADD     = 2'd0,
    ACT_RESTART = 2'd1,
    ACT_STEP    = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  // configuration register indexes
  localparam logic CFG_START_STATE = 1'b0;
  localparam logic CFG_ACCEPT_MASK = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_MOVE,
    ST_CLOSE
  } state_e;

  // input beat
  typedef struct packed {
    logic [ActW-1:0]   action;
    logic [StateW-1:0] from_state;
    logic [SymW-1:0]   symbol;
    logic [StateW-1:0] to_state;
  } item_t;

  // result beat
  typedef struct packed {
    logic [SetW-1:0] active_set;
    logic            accepting;
  } result_t;

  // command broadcast along the row of cells
  typedef struct packed {
    logic            rd_en;
    logic            wr_en;
    logic            clr;
    logic [SymW-1:0] addr;
  } cell_cmd_t;

endpackage

>>> rtl/nfa_state_set_stepper.sv
// ----------------------------------------------------------------------------
// nfa_state_set_stepper
// NFA simulator on a state bitmask with epsilon closure.
// ----------------------------------------------------------------------------
// After reset the block sweeps its transition store clear, every symbol
// row, with busy high. An item is taken when start is high and busy low.
// Unused actions and ignored adds give their result on the next cycle; an
// add reads the row, then writes it; a restart runs closure passes, and a
// step reads the row and moves the set before its closure passes, which
// repeat through the OR chain in the row of cells until the set stops
// growing. Each result shows on result_o for one cycle with result_valid_o
// and cannot be held off.
module nfa_state_set_stepper #(
  parameter int NUM_STATES  = nfass_pkg::NumStatesDef,
  parameter int NUM_SYMBOLS = nfass_pkg::NumSymbolsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  nfass_pkg::item_t              item_i,
  output logic                          result_valid_o,
  output nfass_pkg::result_t            result_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [nfass_pkg::CfgW-1:0]    cfg_wdata_i
);

  localparam int AddrW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam logic [NUM_STATES-1:0] One = {{(NUM_STATES-1){1'b0}}, 1'b1};

  nfass_pkg::state_e state_q, state_d;
  nfass_pkg::item_t  item_q, item_d;
  logic [NUM_STATES-1:0] active_q, active_d;
  logic [AddrW-1:0]      clr_q, clr_d;
  logic                  done_q, done_d;
  nfass_pkg::result_t    res_q, res_d;
  logic [nfass_pkg::StateW-1:0] start_q;
  logic [nfass_pkg::SetW-1:0]   accept_q;

  nfass_pkg::cell_cmd_t  cmd;
  logic [NUM_STATES-1:0] set_mask;
  logic [NUM_STATES-1:0] move_c  [NUM_STATES+1];
  logic [NUM_STATES-1:0] close_c [NUM_STATES+1];
  logic [NUM_STATES-1:0] grown;
  logic [nfass_pkg::SetW-1:0] shown;
  logic add_ok;
  logic sym_ok;
  logic start_ok;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= nfass_pkg::StateW'(1);
      accept_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nfass_pkg::CFG_START_STATE: start_q  <= cfg_wdata_i[nfass_pkg::StateW-1:0];
        nfass_pkg::CFG_ACCEPT_MASK: accept_q <= cfg_wdata_i[nfass_pkg::SetW-1:0];
        default: ;
      endcase
    end
  end

  // range checks on the incoming item, the held item and the start state
  assign sym_ok   = 32'(item_q.symbol) < NUM_SYMBOLS;
  assign add_ok   = (item_i.from_state != '0) && (32'(item_i.from_state) < NUM_STATES)
                    && (32'(item_i.to_state) < NUM_STATES)
                    && (32'(item_i.symbol) < NUM_SYMBOLS);
  assign start_ok = 32'(start_q) < NUM_STATES;
  assign set_mask = One << item_q.to_state;

  // row of cells
  assign move_c[0]  = '0;
  assign close_c[0] = '0;
  for (genvar k = 0; k < NUM_STATES; k++) begin : g_cell
    nfass_cell #(
      .NUM_STATES (NUM_STATES),
      .NUM_SYMBOLS(NUM_SYMBOLS)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .sel_i     (32'(item_q.from_state) == k),
      .set_mask_i(set_mask),
      .active_i  (active_q[k]),
      .move_i    (move_c[k]),
      .move_o    (move_c[k+1]),
      .close_i   (close_c[k]),
      .close_o   (close_c[k+1])
    );
  end

  assign grown = active_q | close_c[NUM_STATES];

  // visible part of the active set
  if (NUM_STATES >= nfass_pkg::SetW) begin : g_wide
    assign shown = active_q[nfass_pkg::SetW-1:0];
  end else begin : g_narrow
    assign shown = {{(nfass_pkg::SetW-NUM_STATES){1'b0}}, active_q};
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= nfass_pkg::ST_CLEAR;
      active_q <= '0;
      clr_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      clr_q    <= clr_d;
      done_q   <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
  end

  // next state and cell commands
  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    active_d  = active_q;
    clr_d     = clr_q;
    done_d    = 1'b0;
    cmd       = '0;
    cmd.addr  = item_q.symbol;
    case (state_q)
      nfass_pkg::ST_CLEAR: begin
        cmd.clr  = 1'b1;
        cmd.addr = nfass_pkg::SymW'(clr_q);
        clr_d    = clr_q + AddrW'(1);
        if (clr_q == AddrW'(NUM_SYMBOLS - 1)) begin
          state_d = nfass_pkg::ST_IDLE;
        end
      end
      nfass_pkg::ST_IDLE: begin
        if (start) begin
          item_d = item_i;
          case (nfass_pkg::action_e'(item_i.action))
            nfass_pkg::ACT_ADD: begin
              if (add_ok) state_d = nfass_pkg::ST_READ;
              else done_d = 1'b1;
            end
            nfass_pkg::ACT_RESTART: begin
              active_d = start_ok ? (One << start_q) : '0;
              state_d  = nfass_pkg::ST_CLOSE;
            end
            nfass_pkg::ACT_STEP: state_d = nfass_pkg::ST_READ;
            default: done_d = 1'b1;
          endcase
        end
      end
      nfass_pkg::ST_READ: begin
        cmd.rd_en = sym_ok;
        if (nfass_pkg::action_e'(item_q.action) == nfass_pkg::ACT_ADD) begin
          state_d = nfass_pkg::ST_WRITE;
        end else if (sym_ok) begin
          state_d = nfass_pkg::ST_MOVE;
        end else begin
          // no moves on a symbol beyond the alphabet
          active_d = '0;
          state_d  = nfass_pkg::ST_CLOSE;
        end
      end
      nfass_pkg::ST_WRITE: begin
        cmd.wr_en = 1'b1;
        done_d    = 1'b1;
        state_d   = nfass_pkg::ST_IDLE;
      end
      nfass_pkg::ST_MOVE: begin
        active_d = move_c[NUM_STATES];
        state_d  = nfass_pkg::ST_CLOSE;
      end
      nfass_pkg::ST_CLOSE: begin
        // one closure pass a cycle until the set stops growing
        if (grown == active_q) begin
          done_d  = 1'b1;
          state_d = nfass_pkg::ST_IDLE;
        end else begin
          active_d = grown;
        end
      end
      default: state_d = nfass_pkg::ST_IDLE;
    endcase
  end

  // result beat built from the set it reports
  always_comb begin
    res_d = res_q;
    if (done_d) begin
      res_d.active_set = nfass_pkg::SetW'(active_d);
      res_d.accepting  = |(nfass_pkg::SetW'(active_d) & accept_q);
    end
  end

  assign busy           = state_q != nfass_pkg::ST_IDLE;
  assign result_valid_o = done_q;
  assign result_o       = res_q;

`ifndef SYNTHESIS
  // a taken item is either in progress or answered next cycle
  a_take_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || result_valid_o))
    else $error("taken item neither running nor answered");

  // results only appear once the sequencer is back at rest
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result beat while busy");

  // closure passes only ever add states
  a_close_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nfass_pkg::ST_CLOSE && $past(state_q) == nfass_pkg::ST_CLOSE)
      |-> ((active_q & $past(active_q)) == $past(active_q)))
    else $error("closure pass dropped a state");

  // the reported set is what the sequencer holds
  a_result_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.active_set == shown))
    else $error("result set differs from active set");
`endif

endmodule

>>> rtl/nfass_cell.sv
// ----------------------------------------------------------------------------
// nfass_cell
// One automaton state: its target rows per symbol, its epsilon row, and its
// link in the move and closure OR chains.
// ----------------------------------------------------------------------------
module nfass_cell #(
  parameter int NUM_STATES  = nfass_pkg::NumStatesDef,
  parameter int NUM_SYMBOLS = nfass_pkg::NumSymbolsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  nfass_pkg::cell_cmd_t  cmd_i,
  input  logic                  sel_i,
  input  logic [NUM_STATES-1:0] set_mask_i,
  input  logic                  active_i,
  input  logic [NUM_STATES-1:0] move_i,
  output logic [NUM_STATES-1:0] move_o,
  input  logic [NUM_STATES-1:0] close_i,
  output logic [NUM_STATES-1:0] close_o
);

  localparam int AddrW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;

  logic [NUM_STATES-1:0] mem [NUM_SYMBOLS];
  logic [NUM_STATES-1:0] rdata_q;
  logic [NUM_STATES-1:0] eps_q;
  logic [AddrW-1:0]      addr;

  assign addr = cmd_i.addr[AddrW-1:0];

  // row store: registered read, read-modify-write on add, zero on clear
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem[addr];
    end
    if (cmd_i.clr) begin
      mem[addr] <= '0;
    end else if (cmd_i.wr_en && sel_i) begin
      mem[addr] <= rdata_q | set_mask_i;
    end
  end

  // epsilon row kept in flops for the closure passes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= '0;
    end else if (cmd_i.wr_en && sel_i && (cmd_i.addr == '0)) begin
      eps_q <= eps_q | set_mask_i;
    end
  end

  // chain links
  assign move_o  = move_i  | (active_i ? rdata_q : '0);
  assign close_o = close_i | (active_i ? eps_q   : '0);

endmodule
